[hdl/tli_pkg.sv]
`timescale 1ns / 1ps

package tli_pkg;

	// operation codes of a request
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Q16.16 limits
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// restoring divide: one quotient bit per cycle over the 64-bit product
	localparam int DIV_STEPS = 64;
	// quotient at or above 2^40 always clips
	localparam int QUOT_CLIP_BIT = 40;

	typedef struct packed {
		logic        valid;
		logic [31:0] mag_a;  // |dy|
		logic [31:0] mag_b;  // |dq|
		logic [31:0] mag_d;  // |dx|, never zero
	} tli_div_req_t;

endpackage

[hdl/tli_ram.sv]
`timescale 1ns / 1ps

module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/tli_div.sv]
`timescale 1ns / 1ps

module tli_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tli_pkg::tli_div_req_t req,
	output logic                 done,
	output logic [63:0]          quot
);

	import tli_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE,
		D_MUL,
		D_RUN
	} div_state_t;

	localparam int CW = $clog2(DIV_STEPS);

	div_state_t      state_q;
	logic [31:0]     a_q;
	logic [31:0]     b_q;
	logic [31:0]     d_q;
	logic [63:0]     acc_q;   // product, then quotient shifted in from the bottom
	logic [31:0]     rem_q;
	logic [CW-1:0]   cnt_q;
	logic            done_q;

	logic [32:0]     shifted;
	logic            take;
	logic [32:0]     diff;

	always_comb begin
		shifted = {rem_q, acc_q[63]};
		take    = (shifted >= {1'b0, d_q});
		diff    = shifted - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.valid) begin
						a_q     <= req.mag_a;
						b_q     <= req.mag_b;
						d_q     <= req.mag_d;
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					acc_q   <= 64'(a_q) * 64'(b_q);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= D_RUN;
				end
				D_RUN: begin
					rem_q <= take ? diff[31:0] : shifted[31:0];
					acc_q <= {acc_q[62:0], take};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

[hdl/table_linear_interpolator.sv]
`timescale 1ns / 1ps
// Write request: busy stays low, no result strobe.
// Query request: busy through the scan, segment reads, difference step and any divide.
// Scan ends at the first slot with x at or below the query, else at table_length - 2.
// Rate is set by the one-slot-per-cycle scan of the x memory and the 64-step divider.
// Result strobe lasts one cycle and cannot be stalled. Reset clears control and sets
// table_length to 2; table memories are not cleared and must be written before use.
module table_linear_interpolator #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [5:0]  point_index,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] query_x,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	output logic        result_valid,
	output logic [31:0] result_y,
	output logic        zero_span,
	output logic        saturated
);

	import tli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int LW = $clog2(MAX_POINTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEG_LO,
		ST_SEG_HI,
		ST_DIFF,
		ST_DIVW
	} state_t;

	state_t             state_q;
	logic [6:0]         table_length_q;
	logic signed [31:0] q_q;
	logic [AW-1:0]      last_q;       // last slot the scan checks
	logic [AW-1:0]      end_q;        // upper point when the scan finds nothing
	logic [AW-1:0]      rd_idx_q;
	logic               chk_vld_s1;
	logic [AW-1:0]      chk_idx_s1;
	logic [AW-1:0]      seg_hi_q;
	logic [31:0]        x0_q;
	logic [31:0]        y0_q;
	logic               neg_q;
	tli_div_req_t       div_req_q;
	logic               res_vld_q;
	logic [31:0]        res_y_q;
	logic               res_zero_q;
	logic               res_sat_q;

	logic               accept;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [31:0]        x_rd;
	logic [31:0]        y_rd;
	logic [LW-1:0]      eff_len;

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] dq;
	logic [32:0]        dx_neg;
	logic [32:0]        dy_neg;
	logic [32:0]        dq_neg;
	logic [31:0]        dx_mag;
	logic [31:0]        dy_mag;
	logic [31:0]        dq_mag;
	logic               neg_w;

	logic               div_done;
	logic [63:0]        quot;
	logic               quot_big;
	logic signed [41:0] sum_w;
	logic               ovf_hi;
	logic               ovf_lo;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign wr_en   = accept && (operation == OP_WRITE) && (32'(point_index) < MAX_POINTS);
	assign wr_addr = AW'(point_index);

	always_comb begin
		if (table_length_q < 7'd2) begin
			eff_len = LW'(2);
		end else if (32'(table_length_q) > MAX_POINTS) begin
			eff_len = LW'(MAX_POINTS);
		end else begin
			eff_len = LW'(table_length_q);
		end
	end

	always_comb begin
		unique case (state_q)
			ST_SEG_LO: rd_addr = seg_hi_q - AW'(1);
			ST_SEG_HI: rd_addr = seg_hi_q;
			default:   rd_addr = rd_idx_q;
		endcase
	end

	tli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (point_x),
		.raddr (rd_addr),
		.rdata (x_rd)
	);

	tli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (point_y),
		.raddr (rd_addr),
		.rdata (y_rd)
	);

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quot   (quot)
	);

	// segment differences; x_rd/y_rd hold the upper point in ST_DIFF
	always_comb begin
		dx     = $signed({x_rd[31], x_rd}) - $signed({x0_q[31], x0_q});
		dy     = $signed({y_rd[31], y_rd}) - $signed({y0_q[31], y0_q});
		dq     = $signed({q_q[31], q_q}) - $signed({x0_q[31], x0_q});
		dx_neg = -dx;
		dy_neg = -dy;
		dq_neg = -dq;
		dx_mag = dx[32] ? dx_neg[31:0] : dx[31:0];
		dy_mag = dy[32] ? dy_neg[31:0] : dy[31:0];
		dq_mag = dq[32] ? dq_neg[31:0] : dq[31:0];
		neg_w  = ((dy[32] != dq[32]) != dx[32]) && (dy != '0) && (dq != '0);
	end

	always_comb begin
		quot_big = |quot[63:QUOT_CLIP_BIT];
		if (neg_q) begin
			sum_w = $signed({{10{y0_q[31]}}, y0_q}) - $signed({2'b00, quot[39:0]});
		end else begin
			sum_w = $signed({{10{y0_q[31]}}, y0_q}) + $signed({2'b00, quot[39:0]});
		end
		ovf_hi = !sum_w[41] && (|sum_w[40:31]);
		ovf_lo = sum_w[41] && !(&sum_w[40:31]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			table_length_q <= 7'd2;
			chk_vld_s1     <= 1'b0;
			div_req_q      <= '0;
			res_vld_q      <= 1'b0;
		end else begin
			res_vld_q       <= 1'b0;
			div_req_q.valid <= 1'b0;
			if (cfg_wr_en) begin
				table_length_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && operation == OP_QUERY) begin
						q_q        <= $signed(query_x);
						last_q     <= AW'(eff_len - LW'(2));
						end_q      <= AW'(eff_len - LW'(1));
						rd_idx_q   <= '0;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// read of rd_idx_q is in flight while chk_idx_s1 is compared
					chk_vld_s1 <= 1'b1;
					chk_idx_s1 <= rd_idx_q;
					if (rd_idx_q != last_q) begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
					if (chk_vld_s1) begin
						if ($signed(x_rd) <= q_q) begin
							seg_hi_q   <= (chk_idx_s1 == '0) ? AW'(1) : chk_idx_s1;
							chk_vld_s1 <= 1'b0;
							state_q    <= ST_SEG_LO;
						end else if (chk_idx_s1 == last_q) begin
							seg_hi_q   <= end_q;
							chk_vld_s1 <= 1'b0;
							state_q    <= ST_SEG_LO;
						end
					end
				end
				ST_SEG_LO: begin
					state_q <= ST_SEG_HI;
				end
				ST_SEG_HI: begin
					x0_q    <= x_rd;
					y0_q    <= y_rd;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (dx == '0) begin
						res_vld_q  <= 1'b1;
						res_y_q    <= y_rd;
						res_zero_q <= 1'b1;
						res_sat_q  <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						div_req_q <= '{valid: 1'b1, mag_a: dy_mag, mag_b: dq_mag,
							mag_d: dx_mag};
						neg_q     <= neg_w;
						state_q   <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						res_vld_q  <= 1'b1;
						res_zero_q <= 1'b0;
						priority if (quot_big) begin
							res_y_q   <= neg_q ? Q_MIN : Q_MAX;
							res_sat_q <= 1'b1;
						end else if (ovf_hi) begin
							res_y_q   <= Q_MAX;
							res_sat_q <= 1'b1;
						end else if (ovf_lo) begin
							res_y_q   <= Q_MIN;
							res_sat_q <= 1'b1;
						end else begin
							res_y_q   <= sum_w[31:0];
							res_sat_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign result_y     = res_y_q;
	assign zero_span    = res_zero_q;
	assign saturated    = res_sat_q;

	// a result only ever closes out a query in progress
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a query in progress");

	// a write request produces no result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_WRITE) |=> !result_valid)
		else $error("result strobe after a write request");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_QUERY) |=> busy)
		else $error("query accepted but block not busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(zero_span && saturated))
		else $error("zero span and saturation flagged together");

	// divider is only started from the difference step
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req_q.valid |-> (state_q == ST_DIVW) && $past(state_q == ST_DIFF))
		else $error("divider started outside the difference step");

endmodule

[dv/tb_table_linear_interpolator.sv]
`timescale 1ns / 1ps

module tb_table_linear_interpolator;
	import tli_pkg::*;

	localparam int MAX_POINTS = 64;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int SETTLE_CYCLES = 150;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -64'sd2147483648;

	typedef struct packed {
		logic        op;
		logic [5:0]  slot;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] qx;
	} request_t;

	typedef struct packed {
		logic [31:0] level;
		logic        zero_seg;
		logic        clip;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = OP_WRITE;
	logic [5:0]  point_index = '0;
	logic [31:0] point_x = '0;
	logic [31:0] point_y = '0;
	logic [31:0] query_x = '0;
	logic        cfg_wr_en = 1'b0;
	logic [6:0]  cfg_wr_data = '0;
	logic        result_valid;
	logic [31:0] result_y;
	logic        zero_span;
	logic        saturated;

	table_linear_interpolator #(.MAX_POINTS(MAX_POINTS)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.query_x     (query_x),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.result_valid(result_valid),
		.result_y    (result_y),
		.zero_span   (zero_span),
		.saturated   (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	int          tbl_x[MAX_POINTS];
	int          tbl_y[MAX_POINTS];
	logic [6:0]  tbl_len = 7'd2;

	// stimulus side copy of the abscissas, used to aim queries and rewrites of points
	int          plan_x[MAX_POINTS];

	request_t    pending_reqs[$];
	answer_t     expected_answers[$];
	request_t    cur_req;
	int          burst_left = 1;
	int          gap_left = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          phase_len[10] = '{64, 0, 127, 1, 65, 2, 5, 33, 12, -1};

	function automatic int span_points(logic [6:0] v);
		return (v < 2) ? 2 : (v > MAX_POINTS) ? MAX_POINTS : int'(v);
	endfunction

	function automatic int rand_near(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic answer_t interpolate_at(logic [31:0] q_bits);
		answer_t     a;
		int          n;
		int          i;
		longint      q;
		longint      x0;
		longint      x1;
		longint      y0;
		longint      y1;
		longint      dx;
		longint      dy;
		longint      dq;
		longint      sum;
		logic [63:0] mag_x;
		logic [63:0] mag_y;
		logic [63:0] mag_q;
		logic [63:0] quot;
		logic        neg;
		n = span_points(tbl_len);
		q = longint'($signed(q_bits));
		i = 1;
		while (i < n && longint'(tbl_x[i - 1]) > q)
			i++;
		if (i > 1)
			i--;
		x0 = tbl_x[i - 1];
		x1 = tbl_x[i];
		y0 = tbl_y[i - 1];
		y1 = tbl_y[i];
		dx = x1 - x0;
		a.zero_seg = 1'b0;
		a.clip = 1'b0;
		if (dx == 0) begin
			a.level = y1[31:0];
			a.zero_seg = 1'b1;
			return a;
		end
		dy = y1 - y0;
		dq = q - x0;
		neg = ((dy < 0) != (dq < 0)) != (dx < 0);
		if (dy == 0 || dq == 0)
			neg = 1'b0;
		mag_x = (dx < 0) ? -dx : dx;
		mag_y = (dy < 0) ? -dy : dy;
		mag_q = (dq < 0) ? -dq : dq;
		quot = (mag_y * mag_q) / mag_x;
		if (quot >= (64'd1 << QUOT_CLIP_BIT)) begin
			a.clip = 1'b1;
			sum = neg ? Q_LO : Q_HI;
		end else begin
			sum = neg ? y0 - longint'(quot) : y0 + longint'(quot);
			if (sum > Q_HI) begin
				sum = Q_HI;
				a.clip = 1'b1;
			end else if (sum < Q_LO) begin
				sum = Q_LO;
				a.clip = 1'b1;
			end
		end
		a.level = sum[31:0];
		return a;
	endfunction

	task automatic apply_request(request_t r);
		if (r.op == OP_WRITE) begin
			tbl_x[r.slot] = r.px;
			tbl_y[r.slot] = r.py;
		end else begin
			expected_answers.push_back(interpolate_at(r.qx));
		end
	endtask

	task automatic queue_write(int slot, int x, int y);
		request_t r;
		r.op = OP_WRITE;
		r.slot = 6'(slot);
		r.px = x;
		r.py = y;
		r.qx = $urandom;
		pending_reqs.push_back(r);
		plan_x[slot] = x;
	endtask

	task automatic queue_query(int q);
		request_t r;
		r.op = OP_QUERY;
		r.slot = 6'($urandom);
		r.px = $urandom;
		r.py = $urandom;
		r.qx = q;
		pending_reqs.push_back(r);
	endtask

	// sampled on the falling edge so the driver's pops and drives have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || busy || expected_answers.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// request driver: bursts of requests separated by random gaps
	always @(posedge clk) begin
		logic drive;
		if (arst_n) begin
			drive = 1'b0;
			if (start && !busy) begin
				apply_request(cur_req);
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: gap_left = 0;
						4, 5, 6, 7: gap_left = $urandom_range(1, 4);
						8: gap_left = $urandom_range(5, 30);
						default: gap_left = $urandom_range(31, 150);
					endcase
				end
			end
			if (start && busy) begin
				drive = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() != 0) begin
				cur_req = pending_reqs.pop_front();
				drive = 1'b1;
			end
			start <= drive;
			if (drive) begin
				operation <= cur_req.op;
				point_index <= cur_req.slot;
				point_x <= cur_req.px;
				point_y <= cur_req.py;
				query_x <= cur_req.qx;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && result_valid) begin
			if (expected_answers.size() == 0) begin
				$error("result strobe with no query outstanding, result_y %h", result_y);
				mismatches++;
			end else begin
				want = expected_answers.pop_front();
				if (result_y !== want.level) begin
					$error("result_y expected %h actual %h", want.level, result_y);
					mismatches++;
				end
				if (zero_span !== want.zero_seg) begin
					$error("zero_span expected %b actual %b", want.zero_seg, zero_span);
					mismatches++;
				end
				if (saturated !== want.clip) begin
					$error("saturated expected %b actual %b", want.clip, saturated);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		int cfg_val;
		int style;
		int k;
		int k2;
		int q;
		int x;
		int lo;
		int hi;
		int y;
		int xs[$];

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single segment: x falls 10.0 -> 0.0 while y rises 0 -> 100.0
		queue_write(0, 32'h000A_0000, 0);
		queue_write(1, 0, 32'h0064_0000);
		queue_query(32'h0005_0000);
		queue_query(32'h000A_0000);
		queue_query(0);
		queue_query(32'h7FFF_FFFF);
		queue_query(32'h8000_0000);
		// both points at the same x
		queue_write(0, 0, 32'h0001_0000);
		queue_query(32'h0003_0000);
		queue_query(32'h8000_0000);
		// points at the corners of the number range
		queue_write(0, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_write(1, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_query(0);
		queue_query(32'h8000_0000);
		queue_query(32'h7FFF_FFFF);
		// one-LSB span with full-scale rise: quotient runs past the clip bit
		queue_write(0, 1, 32'h7FFF_FFFF);
		queue_write(1, 0, 32'h8000_0000);
		queue_query(32'h7FFF_FFFF);
		queue_query(32'h8000_0000);
		// rising x, flat y
		queue_write(0, 0, 32'h0002_0000);
		queue_write(1, 32'h0004_0000, 32'h0002_0000);
		queue_query(32'h0001_0000);
		// top slot, outside the active length
		queue_write(63, $urandom, $urandom);
		queue_query(32'hFFFF_0000);

		foreach (phase_len[p]) begin
			wait_idle();
			cfg_val = (phase_len[p] < 0) ? $urandom_range(0, 127) : phase_len[p];
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= 7'(cfg_val);
			tbl_len = 7'(cfg_val);
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			@(negedge clk);
			n = span_points(7'(cfg_val));

			// fresh table: wide falling, narrow falling, narrow with repeats, or unordered
			style = $urandom_range(0, 3);
			xs.delete();
			repeat (n) xs.push_back((style == 0) ? int'($urandom) : rand_near(32'h0040_0000));
			if (style != 3)
				xs.rsort();
			for (int j = 1; j < n; j++)
				if (style == 2 && $urandom_range(0, 3) == 0)
					xs[j] = xs[j - 1];
			for (int j = 0; j < n; j++)
				queue_write(j, xs[j], (style == 0) ? int'($urandom) : rand_near(32'h0100_0000));

			repeat (ITEMS_PER_PHASE) begin
				k = $urandom_range(0, n - 1);
				k2 = (k < n - 1) ? k + 1 : k;
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
						case ($urandom_range(0, 5))
							0: q = $urandom;
							1: q = plan_x[k];
							2: q = plan_x[k] + rand_near(32'h0001_0000);
							3: q = int'((longint'(plan_x[k]) + longint'(plan_x[k2])) / 2);
							4: begin
								case ($urandom_range(0, 2))
									0: q = 32'h7FFF_FFFF;
									1: q = 32'h8000_0000;
									default: q = 0;
								endcase
							end
							default: begin
								if ($urandom_range(0, 1))
									q = plan_x[0] + int'($urandom_range(1, 32'h0010_0000));
								else
									q = plan_x[n - 1] - int'($urandom_range(1, 32'h0010_0000));
							end
						endcase
						queue_query(q);
					end
					13, 14, 15, 16, 17: begin
						hi = (k > 0) ? plan_x[k - 1] : plan_x[k] + 32'h0001_0000;
						lo = (k < n - 1) ? plan_x[k + 1] : plan_x[k] - 32'h0001_0000;
						case ($urandom_range(0, 3))
							0: x = int'(longint'(lo) +
								(longint'(hi) - longint'(lo)) * $urandom_range(0, 255) / 255);
							1: x = $urandom_range(0, 1) ? hi : lo;
							2: x = $urandom;
							default: x = plan_x[k] + rand_near(4096);
						endcase
						y = ($urandom_range(0, 3) == 0) ? int'($urandom) : rand_near(32'h0100_0000);
						queue_write(k, x, y);
					end
					default: queue_write($urandom_range(0, MAX_POINTS - 1), $urandom, $urandom);
				endcase
			end
		end

		wait_idle();
		if (expected_answers.size() != 0) begin
			$error("%0d expected results never arrived", expected_answers.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/tli_pkg.sv
hdl/tli_ram.sv
hdl/tli_div.sv
hdl/table_linear_interpolator.sv
dv/tb_table_linear_interpolator.sv
